FILE: hdl/strm_pkg.sv
// shared constants, types and helper functions for the sparse table range minimum engine
package strm_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int NUM_LEVELS   = 11;
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int LVL_W        = $clog2(NUM_LEVELS);
    localparam int TBL_DEPTH    = NUM_LEVELS * MAX_ELEMENTS;
    localparam int ADDR_W       = $clog2(TBL_DEPTH);
    localparam int POS_W        = 11;
    localparam int SPAN_W       = POS_W + 2;
    localparam int DATA_W       = 32;
    localparam int OP_W         = 2;
    localparam int S_TDATA_W    = 56;
    localparam int S_TUSER_W    = 2;
    localparam int M_TDATA_W    = 32;
    localparam int M_TUSER_W    = 2;

    localparam logic [DATA_W-1:0] EMPTY_ANSWER = 32'd1000000000;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_BUILD = 2'd1,
        OP_QUERY = 2'd2
    } opcode_t;

    typedef struct packed {
        logic              re;
        logic [ADDR_W-1:0] raddr_a;
        logic [ADDR_W-1:0] raddr_b;
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
    } mem_req_t;

    function automatic logic [DATA_W-1:0] smin(input logic [DATA_W-1:0] a,
                                               input logic [DATA_W-1:0] b);
        return ($signed(a) <= $signed(b)) ? a : b;
    endfunction

    function automatic logic [LVL_W-1:0] floor_log2(input logic [POS_W-1:0] w);
        int h;
        h = 0;
        for (int i = 0; i < POS_W; i++)
        begin
            if (w[i])
            begin
                h = i;
            end
        end
        if (h > NUM_LEVELS - 1)
        begin
            h = NUM_LEVELS - 1;
        end
        return LVL_W'(h);
    endfunction

    function automatic logic [ADDR_W-1:0] tbl_addr(input logic [LVL_W-1:0] lvl,
                                                   input logic [IDX_W-1:0] idx);
        return ADDR_W'(int'(lvl) * MAX_ELEMENTS + int'(idx));
    endfunction

endpackage

FILE: hdl/strm_ram.sv
// generic ram, one write port and two registered read ports
module strm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

FILE: hdl/strm_ctrl.sv
// sequencer for load, build and query transfers around the table memory
module strm_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [strm_pkg::POS_W-1:0]        len,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [strm_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic [strm_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [strm_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic [strm_pkg::M_TUSER_W-1:0]    m_tuser,
    output strm_pkg::mem_req_t                mem_req,
    input  logic [strm_pkg::DATA_W-1:0]       rdata_a,
    input  logic [strm_pkg::DATA_W-1:0]       rdata_b
);
    import strm_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_BUILD = 4'b0010,
        ST_QADDR = 4'b0100,
        ST_QREAD = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [POS_W-1:0]    left_reg, left_next;
    logic [POS_W-1:0]    right_reg, right_next;
    logic [LVL_W-1:0]    lvl_reg, lvl_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                pend_reg, pend_next;
    logic [ADDR_W-1:0]   pend_addr_reg, pend_addr_next;
    logic                empty_reg, empty_next;
    logic                bad_reg, bad_next;
    logic                out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]   min_reg, min_next;
    logic [1:0]          flags_reg, flags_next;

    logic                accept;
    opcode_t             in_op;
    logic [POS_W-1:0]    in_pos;
    logic [POS_W-1:0]    in_right;
    logic [DATA_W-1:0]   in_value;
    logic [POS_W-1:0]    len_eff;
    logic [SPAN_W-1:0]   span;
    logic [SPAN_W-1:0]   next_span;
    logic [IDX_W-1:0]    half;
    logic                fits;
    logic                load_we;
    logic                q_empty;
    logic                q_bad;
    logic [POS_W-1:0]    q_width;
    logic [LVL_W-1:0]    q_lvl;
    logic [POS_W-1:0]    q_span;
    logic                out_free;

    assign in_op    = opcode_t'(s_tuser[OP_W-1:0]);
    assign in_pos   = s_tdata[POS_W-1:0];
    assign in_right = s_tdata[2*POS_W-1:POS_W];
    assign in_value = s_tdata[2*POS_W+DATA_W-1:2*POS_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign len_eff  = (len > POS_W'(MAX_ELEMENTS)) ? POS_W'(MAX_ELEMENTS) : len;

    assign span      = SPAN_W'(1) << lvl_reg;
    assign next_span = span << 1;
    assign half      = IDX_W'(span >> 1);
    assign fits      = (SPAN_W'(idx_reg) + span) <= SPAN_W'(len_eff);

    assign load_we = accept && (in_op == OP_LOAD) && (in_pos != '0) && (in_pos <= len_eff);

    assign q_empty = left_reg > right_reg;
    assign q_bad   = (left_reg == '0) || (right_reg == '0) ||
                     (left_reg > len_eff) || (right_reg > len_eff);
    assign q_width = right_reg - left_reg + POS_W'(1);
    assign q_lvl   = floor_log2(q_width);
    assign q_span  = POS_W'(1) << q_lvl;

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next     = state_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        lvl_next       = lvl_reg;
        idx_next       = idx_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        empty_next     = empty_reg;
        bad_next       = bad_reg;
        out_valid_next = out_valid_reg && !m_tready;
        min_next       = min_reg;
        flags_next     = flags_reg;

        mem_req.re      = 1'b0;
        mem_req.raddr_a = '0;
        mem_req.raddr_b = '0;
        mem_req.we      = load_we || pend_reg;
        mem_req.waddr   = pend_reg ? pend_addr_reg : tbl_addr('0, IDX_W'(in_pos - POS_W'(1)));
        mem_req.wdata   = pend_reg ? smin(rdata_a, rdata_b) : in_value;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_op)
                        OP_BUILD:
                        begin
                            lvl_next   = LVL_W'(1);
                            idx_next   = '0;
                            state_next = ST_BUILD;
                        end
                        OP_QUERY:
                        begin
                            left_next  = in_pos;
                            right_next = in_right;
                            state_next = ST_QADDR;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_BUILD:
            begin
                if (fits)
                begin
                    mem_req.re      = 1'b1;
                    mem_req.raddr_a = tbl_addr(lvl_reg - LVL_W'(1), idx_reg);
                    mem_req.raddr_b = tbl_addr(lvl_reg - LVL_W'(1), idx_reg + half);
                    pend_next       = 1'b1;
                    pend_addr_next  = tbl_addr(lvl_reg, idx_reg);
                    idx_next        = idx_reg + IDX_W'(1);
                end
                else
                begin
                    lvl_next = lvl_reg + LVL_W'(1);
                    idx_next = '0;
                    if ((lvl_reg == LVL_W'(NUM_LEVELS - 1)) || (next_span > SPAN_W'(len_eff)))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_QADDR:
            begin
                empty_next = q_empty;
                bad_next   = q_bad;
                if (!q_empty && !q_bad)
                begin
                    mem_req.re      = 1'b1;
                    mem_req.raddr_a = tbl_addr(q_lvl, IDX_W'(left_reg - POS_W'(1)));
                    mem_req.raddr_b = tbl_addr(q_lvl, IDX_W'(right_reg - q_span));
                end
                state_next = ST_QREAD;
            end
            ST_QREAD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    flags_next     = {bad_reg, empty_reg};
                    if (empty_reg)
                    begin
                        min_next = EMPTY_ANSWER;
                    end
                    else if (bad_reg)
                    begin
                        min_next = '0;
                    end
                    else
                    begin
                        min_next = smin(rdata_a, rdata_b);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg      <= left_next;
        right_reg     <= right_next;
        lvl_reg       <= lvl_next;
        idx_reg       <= idx_next;
        pend_addr_reg <= pend_addr_next;
        empty_reg     <= empty_next;
        bad_reg       <= bad_next;
        min_reg       <= min_next;
        flags_reg     <= flags_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = min_reg;
    assign m_tuser  = flags_reg;

    a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(pend_reg && load_we))
        else $error("build write collides with load write");

    a_pend_in_build: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == ST_BUILD))
        else $error("pending build write outside build");

    a_pend_upper_level: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (pend_addr_reg >= ADDR_W'(MAX_ELEMENTS)))
        else $error("build write targets level zero");

    a_qread_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_QREAD) |->
            ($past(state_reg) == ST_QADDR || $past(state_reg) == ST_QREAD))
        else $error("query result step entered without address step");

endmodule

FILE: hdl/sparse_table_range_min.sv
// top level of the sparse table range minimum engine
//
//  port group   dir  fields (low bit first)
//  s_*          in   tdata: position[10:0], right_bound[21:11], value[53:22]; tuser: opcode
//  m_*          out  tdata: minimum[31:0]; tuser: empty_range, out_of_range
//  cfg_*        in   wr_data: length[10:0], written when wr_en is high
//
//  load: one transfer per cycle, written into level 0 at the accepting edge
//  query: an address step, then a result step that loads the output register; no new transfer meanwhile
//  build: one table entry per cycle plus a level change step per level, bounded by the single write port
//  reset clears control state only; table contents are undefined until loaded or built
//  s_tready is high only while idle; a query result waits in its last step while m_* stalls
module sparse_table_range_min (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [strm_pkg::POS_W-1:0]        cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [strm_pkg::S_TDATA_W-1:0]    s_tdata,   // position, right_bound, value, zero pad
    input  logic [strm_pkg::S_TUSER_W-1:0]    s_tuser,   // opcode
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [strm_pkg::M_TDATA_W-1:0]    m_tdata,   // minimum
    output logic [strm_pkg::M_TUSER_W-1:0]    m_tuser    // empty_range, out_of_range
);
    import strm_pkg::*;

    logic [POS_W-1:0]  length_reg;
    mem_req_t          mem_req;
    logic [DATA_W-1:0] rdata_a;
    logic [DATA_W-1:0] rdata_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            length_reg <= cfg_wr_data;
        end
    end

    strm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .len      (length_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .mem_req  (mem_req),
        .rdata_a  (rdata_a),
        .rdata_b  (rdata_b)
    );

    strm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TBL_DEPTH)
    ) u_table (
        .clk     (clk),
        .we      (mem_req.we),
        .waddr   (mem_req.waddr),
        .wdata   (mem_req.wdata),
        .re      (mem_req.re),
        .raddr_a (mem_req.raddr_a),
        .raddr_b (mem_req.raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

endmodule
